// ===== hw/rtl/iamd_pkg.sv =====
// ----------------------------------------------------------------------------
// iamd_pkg
// Shared function codes, status codes and stage types for the integer ALU.
// ----------------------------------------------------------------------------
package iamd_pkg;

    // function codes
    localparam logic [4:0] FN_ADD   = 5'd0;
    localparam logic [4:0] FN_SUB   = 5'd1;
    localparam logic [4:0] FN_AND   = 5'd2;
    localparam logic [4:0] FN_OR    = 5'd3;
    localparam logic [4:0] FN_XOR   = 5'd4;
    localparam logic [4:0] FN_SLL   = 5'd5;
    localparam logic [4:0] FN_SRL   = 5'd6;
    localparam logic [4:0] FN_SRA   = 5'd7;
    localparam logic [4:0] FN_SEQ   = 5'd8;
    localparam logic [4:0] FN_SNE   = 5'd9;
    localparam logic [4:0] FN_SLT   = 5'd10;
    localparam logic [4:0] FN_SLTU  = 5'd11;
    localparam logic [4:0] FN_MUL   = 5'd12;
    localparam logic [4:0] FN_MULH  = 5'd13;
    localparam logic [4:0] FN_MULHU = 5'd14;
    localparam logic [4:0] FN_DIV   = 5'd15;
    localparam logic [4:0] FN_DIVU  = 5'd16;
    localparam logic [4:0] FN_REM   = 5'd17;
    localparam logic [4:0] FN_REMU  = 5'd18;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    localparam int DIV_STEPS = 32;

    // control that rides along with every word
    typedef struct packed {
        logic [4:0] dest;
        logic [1:0] status;
        logic       do_mul;   // multiply in the mul stage
        logic       do_div;   // restoring steps in the divide stages
        logic       sel_hi;   // result from acc[63:32]
        logic       neg;      // two's complement the selected half
        logic       wide_neg; // negate is of the 64-bit product
    } t_ctl;

    // acc: {remainder, dividend/quotient}, product, or plain result in [31:0]
    typedef struct packed {
        t_ctl        ctl;
        logic [63:0] acc;
        logic [31:0] dvs;
    } t_stage;

endpackage

// ===== hw/rtl/iamd_pre.sv =====
// ----------------------------------------------------------------------------
// iamd_pre
// Decode stage: simple ALU results, operand magnitudes and control flags.
// ----------------------------------------------------------------------------
module iamd_pre (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [4:0]           i_func,
    input  logic [31:0]          i_lhs,
    input  logic [31:0]          i_rhs,
    input  logic [4:0]           i_dest,
    output logic                 o_valid,
    output iamd_pkg::t_stage     o_stage
);

    logic             r_valid;
    iamd_pkg::t_stage r_stage;
    iamd_pkg::t_stage n_stage;
    logic [31:0]      w_simple;
    logic [31:0]      w_mag_a;
    logic [31:0]      w_mag_b;
    logic             w_signed;
    logic [4:0]       w_sh;

    // signed functions work on operand magnitudes
    assign w_signed = (i_func == iamd_pkg::FN_MULH) || (i_func == iamd_pkg::FN_DIV) ||
                      (i_func == iamd_pkg::FN_REM);
    assign w_sh    = i_rhs[4:0];
    assign w_mag_a = (w_signed && i_lhs[31]) ? (32'd0 - i_lhs) : i_lhs;
    assign w_mag_b = (w_signed && i_rhs[31]) ? (32'd0 - i_rhs) : i_rhs;

    // decode
    always_comb begin
        w_simple = 32'd0;
        n_stage.ctl.dest     = i_dest;
        n_stage.ctl.status   = iamd_pkg::ST_OK;
        n_stage.ctl.do_mul   = 1'b0;
        n_stage.ctl.do_div   = 1'b0;
        n_stage.ctl.sel_hi   = 1'b0;
        n_stage.ctl.neg      = 1'b0;
        n_stage.ctl.wide_neg = 1'b0;
        unique case (i_func)
            iamd_pkg::FN_ADD:  w_simple = i_lhs + i_rhs;
            iamd_pkg::FN_SUB:  w_simple = i_lhs - i_rhs;
            iamd_pkg::FN_AND:  w_simple = i_lhs & i_rhs;
            iamd_pkg::FN_OR:   w_simple = i_lhs | i_rhs;
            iamd_pkg::FN_XOR:  w_simple = i_lhs ^ i_rhs;
            iamd_pkg::FN_SLL:  w_simple = i_lhs << w_sh;
            iamd_pkg::FN_SRL:  w_simple = i_lhs >> w_sh;
            iamd_pkg::FN_SRA:  w_simple = $unsigned($signed(i_lhs) >>> w_sh);
            iamd_pkg::FN_SEQ:  w_simple = {31'd0, i_lhs == i_rhs};
            iamd_pkg::FN_SNE:  w_simple = {31'd0, i_lhs != i_rhs};
            iamd_pkg::FN_SLT:  w_simple = {31'd0, $signed(i_lhs) < $signed(i_rhs)};
            iamd_pkg::FN_SLTU: w_simple = {31'd0, i_lhs < i_rhs};
            iamd_pkg::FN_MUL: begin
                n_stage.ctl.do_mul = 1'b1;
            end
            iamd_pkg::FN_MULH: begin
                n_stage.ctl.do_mul   = 1'b1;
                n_stage.ctl.sel_hi   = 1'b1;
                n_stage.ctl.neg      = i_lhs[31] ^ i_rhs[31];
                n_stage.ctl.wide_neg = 1'b1;
            end
            iamd_pkg::FN_MULHU: begin
                n_stage.ctl.do_mul = 1'b1;
                n_stage.ctl.sel_hi = 1'b1;
            end
            iamd_pkg::FN_DIV: begin
                n_stage.ctl.do_div = 1'b1;
                n_stage.ctl.neg    = i_lhs[31] ^ i_rhs[31];
            end
            iamd_pkg::FN_DIVU: begin
                n_stage.ctl.do_div = 1'b1;
            end
            iamd_pkg::FN_REM: begin
                n_stage.ctl.do_div = 1'b1;
                n_stage.ctl.sel_hi = 1'b1;
                n_stage.ctl.neg    = i_lhs[31];
            end
            iamd_pkg::FN_REMU: begin
                n_stage.ctl.do_div = 1'b1;
                n_stage.ctl.sel_hi = 1'b1;
            end
            default: begin
                n_stage.ctl.status = iamd_pkg::ST_ILLEGAL;
            end
        endcase
        if (n_stage.ctl.do_div && (i_rhs == 32'd0)) begin
            n_stage.ctl.status = iamd_pkg::ST_DIVZERO;
        end
        n_stage.acc = (n_stage.ctl.do_mul || n_stage.ctl.do_div) ?
                      {32'd0, w_mag_a} : {32'd0, w_simple};
        n_stage.dvs = w_mag_b;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/iamd_mul.sv =====
// ----------------------------------------------------------------------------
// iamd_mul
// Multiply stage: 32x32 unsigned product of the operand magnitudes.
// ----------------------------------------------------------------------------
module iamd_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  iamd_pkg::t_stage     i_stage,
    output logic                 o_valid,
    output iamd_pkg::t_stage     o_stage
);

    logic             r_valid;
    iamd_pkg::t_stage r_stage;
    iamd_pkg::t_stage n_stage;

    // product replaces the accumulator for multiply words
    always_comb begin
        n_stage = i_stage;
        if (i_stage.ctl.do_mul) begin
            n_stage.acc = {32'd0, i_stage.acc[31:0]} * {32'd0, i_stage.dvs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/iamd_div_step.sv =====
// ----------------------------------------------------------------------------
// iamd_div_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module iamd_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  iamd_pkg::t_stage     i_stage,
    output logic                 o_valid,
    output iamd_pkg::t_stage     o_stage
);

    logic             r_valid;
    iamd_pkg::t_stage r_stage;
    iamd_pkg::t_stage n_stage;
    logic [32:0]      w_trial;
    logic [33:0]      w_diff;
    logic             w_ge;

    // shift in next dividend bit, try subtracting the divisor
    assign w_trial = {i_stage.acc[63:32], i_stage.acc[31]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_stage.dvs};
    assign w_ge    = ~w_diff[33];

    always_comb begin
        n_stage = i_stage;
        if (i_stage.ctl.do_div) begin
            n_stage.acc[63:32] = w_ge ? w_diff[31:0] : w_trial[31:0];
            n_stage.acc[31:0]  = {i_stage.acc[30:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/iamd_post.sv =====
// ----------------------------------------------------------------------------
// iamd_post
// Result stage: half select, sign fix, status and write enable.
// ----------------------------------------------------------------------------
module iamd_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  iamd_pkg::t_stage     i_stage,
    output logic                 o_valid,
    output logic [39:0]          o_data
);

    logic        r_valid;
    logic [39:0] r_data;
    logic [39:0] n_data;
    logic [31:0] w_half;
    logic [31:0] w_inc;
    logic [31:0] w_value;
    logic        w_we;

    assign w_half = i_stage.ctl.sel_hi ? i_stage.acc[63:32] : i_stage.acc[31:0];
    // upper half of a 64-bit negate takes a carry only when the low half is zero
    assign w_inc  = i_stage.ctl.wide_neg ? {31'd0, i_stage.acc[31:0] == 32'd0} : 32'd1;

    always_comb begin
        w_value = i_stage.ctl.neg ? (~w_half + w_inc) : w_half;
        if (i_stage.ctl.status != iamd_pkg::ST_OK) begin
            w_value = 32'd0;
        end
        w_we   = (i_stage.ctl.status == iamd_pkg::ST_OK) && (i_stage.ctl.dest != 5'd0);
        n_data = {i_stage.ctl.status, w_we, i_stage.ctl.dest, w_value};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/integer_alu_mul_div.sv =====
// ----------------------------------------------------------------------------
// integer_alu_mul_div
// 32-bit integer ALU with multiply and divide, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one word per cycle when s_axis_tready is high and returns one result
// word per input word, in order: one decode stage, one multiply stage, 32
// restoring divide stages (one quotient bit each) and one result stage.
// Every function goes through all stages, so latency is the same for all.
// The whole pipe advances together whenever the output register is empty
// or being taken, so s_axis_tready drops only while a finished result waits.
// ----------------------------------------------------------------------------
module integer_alu_mul_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[4:0], lhs[36:5], rhs[68:37], dest[73:69], zero fill [79:74]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value[31:0], dest_out[36:32], write_enable[37], status[39:38]
    output logic [39:0] m_axis_tdata
);

    logic             w_en;
    logic             w_pre_valid;
    iamd_pkg::t_stage w_pre_stage;
    logic             w_mul_valid;
    iamd_pkg::t_stage w_mul_stage;
    logic             w_div_valid [iamd_pkg::DIV_STEPS+1];
    iamd_pkg::t_stage w_div_stage [iamd_pkg::DIV_STEPS+1];

    // global advance
    assign w_en          = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = w_en;

    iamd_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tdata[4:0]),
        .i_lhs   (s_axis_tdata[36:5]),
        .i_rhs   (s_axis_tdata[68:37]),
        .i_dest  (s_axis_tdata[73:69]),
        .o_valid (w_pre_valid),
        .o_stage (w_pre_stage)
    );

    iamd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pre_valid),
        .i_stage (w_pre_stage),
        .o_valid (w_mul_valid),
        .o_stage (w_mul_stage)
    );

    assign w_div_valid[0] = w_mul_valid;
    assign w_div_stage[0] = w_mul_stage;

    // divide chain
    for (genvar g = 0; g < iamd_pkg::DIV_STEPS; g++) begin : g_div
        iamd_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_valid[g]),
            .i_stage (w_div_stage[g]),
            .o_valid (w_div_valid[g+1]),
            .o_stage (w_div_stage[g+1])
        );
    end

    iamd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid[iamd_pkg::DIV_STEPS]),
        .i_stage (w_div_stage[iamd_pkg::DIV_STEPS]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/iamd_checker.sv =====
// ----------------------------------------------------------------------------
// iamd_checker
// Port-level checks for the integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module iamd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // input side is open whenever no result waits
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // write enable only on good status and nonzero destination
    a_we_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[37] |->
            m_axis_tdata[39:38] == iamd_pkg::ST_OK && m_axis_tdata[36:32] != 5'd0)
        else $error("write enable with error or zero destination");

    // error results carry a zero value and a known code
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[39:38] != iamd_pkg::ST_OK |->
            m_axis_tdata[31:0] == 32'd0 &&
            (m_axis_tdata[39:38] == iamd_pkg::ST_ILLEGAL ||
             m_axis_tdata[39:38] == iamd_pkg::ST_DIVZERO))
        else $error("bad error result");

endmodule

bind integer_alu_mul_div iamd_checker u_iamd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 32-bit integer ALU with multiply and divide.
// A directed table covers every function, the operand extremes, illegal codes,
// divide by zero, signed divide overflow and destination zero. Random words
// follow. Each result word is compared against a typed-in value or a
// behavioral model of the ALU, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM  = 1030;
    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  dest;
        logic        wen;
        logic [1:0]  status;
    } t_result;

    typedef struct {
        logic [4:0]  func;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [4:0]  dest;
        logic        known;  // expected value typed in below
        logic [31:0] value;
        logic [1:0]  status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // func, lhs, rhs, dest, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // value, dest_out, write_enable, status

    t_result alu_expected[$];
    int      n_errors;
    int      cycle_cnt;
    logic    stim_done = 1'b0;
    logic    hold_req;
    logic    hold_done;

    integer_alu_mul_div u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // behavioral ALU
    function automatic t_result alu_compute(logic [4:0] func, logic [31:0] a,
                                            logic [31:0] b, logic [4:0] dest);
        t_result     r;
        logic [63:0] prod;
        logic [1:0]  st;
        logic [31:0] v;
        st = iamd_pkg::ST_OK;
        v  = '0;
        case (func) inside
            iamd_pkg::FN_ADD:   v = a + b;
            iamd_pkg::FN_SUB:   v = a - b;
            iamd_pkg::FN_AND:   v = a & b;
            iamd_pkg::FN_OR:    v = a | b;
            iamd_pkg::FN_XOR:   v = a ^ b;
            iamd_pkg::FN_SLL:   v = a << b[4:0];
            iamd_pkg::FN_SRL:   v = a >> b[4:0];
            iamd_pkg::FN_SRA:   v = $signed(a) >>> b[4:0];
            iamd_pkg::FN_SEQ:   v = {31'd0, a == b};
            iamd_pkg::FN_SNE:   v = {31'd0, a != b};
            iamd_pkg::FN_SLT:   v = {31'd0, $signed(a) < $signed(b)};
            iamd_pkg::FN_SLTU:  v = {31'd0, a < b};
            iamd_pkg::FN_MUL:   v = a * b;
            iamd_pkg::FN_MULH: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                v = prod[63:32];
            end
            iamd_pkg::FN_MULHU: begin
                prod = {32'd0, a} * {32'd0, b};
                v = prod[63:32];
            end
            iamd_pkg::FN_DIV, iamd_pkg::FN_DIVU, iamd_pkg::FN_REM, iamd_pkg::FN_REMU: begin
                if (b == 0) begin
                    st = iamd_pkg::ST_DIVZERO;
                end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF &&
                             (func == iamd_pkg::FN_DIV || func == iamd_pkg::FN_REM)) begin
                    v = (func == iamd_pkg::FN_DIV) ? 32'h8000_0000 : 32'd0;
                end else begin
                    case (func)
                        iamd_pkg::FN_DIV:  v = $signed(a) / $signed(b);
                        iamd_pkg::FN_REM:  v = $signed(a) % $signed(b);
                        iamd_pkg::FN_DIVU: v = a / b;
                        default:           v = a % b;
                    endcase
                end
            end
            default:  st = iamd_pkg::ST_ILLEGAL;
        endcase
        if (st != iamd_pkg::ST_OK) v = '0;
        r.value  = v;
        r.dest   = dest;
        r.wen    = (st == iamd_pkg::ST_OK) && (dest != 0);
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // offer one word, wait until it is taken, record its expectation
    task automatic send_word(logic [4:0] func, logic [31:0] lhs, logic [31:0] rhs,
                             logic [4:0] dest, logic known, logic [31:0] value,
                             logic [1:0] status);
        t_result exp_r;
        int      gap;
        gap = ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                            : $urandom_range(1, 3)) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        exp_r = alu_compute(func, lhs, rhs, dest);
        if (known) begin
            exp_r.value  = value;
            exp_r.status = status;
            exp_r.wen    = (status == iamd_pkg::ST_OK) && (dest != 0);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, dest, rhs, lhs, func};
        do @(posedge i_clk); while (!s_axis_tready);
        alu_expected.push_back(exp_r);
    endtask

    // directed stimulus
    t_row rows[] = '{
        '{iamd_pkg::FN_ADD,   32'hFFFF_FFFF, 32'd1,
          5'd1,  1, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SUB,   32'd0,         32'd1,
          5'd31, 1, 32'hFFFF_FFFF, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_AND,   32'hF0F0_F0F0, 32'hFFFF_0000,
          5'd2,  0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_OR,    32'hF0F0_F0F0, 32'h0F0F_0000,
          5'd3,  0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_XOR,   32'hFFFF_FFFF, 32'hAAAA_AAAA,
          5'd4,  0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SLL,   32'd1,         32'hFFFF_FFFF,
          5'd5,  1, 32'h8000_0000, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SRL,   32'h8000_0000, 32'd31,
          5'd6,  1, 32'd1,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SRA,   32'h8000_0000, 32'd31,
          5'd7,  1, 32'hFFFF_FFFF, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SRA,   32'h8000_0000, 32'd32,
          5'd7,  1, 32'h8000_0000, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SEQ,   32'h1234_5678, 32'h1234_5678,
          5'd8,  0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SNE,   32'h1234_5678, 32'h1234_5678,
          5'd9,  0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SLT,   32'h8000_0000, 32'h7FFF_FFFF,
          5'd10, 1, 32'd1,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_SLTU,  32'h8000_0000, 32'h7FFF_FFFF,
          5'd11, 1, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF,
          5'd12, 1, 32'd1,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_MULH,  32'hFFFF_FFFF, 32'hFFFF_FFFF,
          5'd13, 1, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_MULH,  32'h8000_0000, 32'h8000_0000,
          5'd13, 1, 32'h4000_0000, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          5'd14, 1, 32'hFFFF_FFFE, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_DIV,   32'h8000_0000, 32'hFFFF_FFFF,
          5'd15, 1, 32'h8000_0000, iamd_pkg::ST_OK},
        '{iamd_pkg::FN_REM,   32'h8000_0000, 32'hFFFF_FFFF,
          5'd17, 1, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_DIV,   -32'sd7,       32'd2,
          5'd15, 0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_REM,   -32'sd7,       32'd2,
          5'd17, 0, 32'd0,         iamd_pkg::ST_OK},
        '{iamd_pkg::FN_DIVU,  32'hFFFF_FFFF, 32'd0,
          5'd16, 1, 32'd0,         iamd_pkg::ST_DIVZERO},
        '{iamd_pkg::FN_REMU,  32'd5,         32'd0,
          5'd18, 1, 32'd0,         iamd_pkg::ST_DIVZERO},
        '{5'd19,              32'd1,         32'd1,
          5'd1,  1, 32'd0,         iamd_pkg::ST_ILLEGAL},
        '{5'd31,              32'd1,         32'd1,
          5'd31, 1, 32'd0,         iamd_pkg::ST_ILLEGAL},
        '{iamd_pkg::FN_ADD,   32'd3,         32'd4,
          5'd0,  1, 32'd7,         iamd_pkg::ST_OK}
    };

    // sender
    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        hold_req      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k])
            send_word(rows[k].func, rows[k].lhs, rows[k].rhs, rows[k].dest,
                      rows[k].known, rows[k].value, rows[k].status);
        for (int n = 0; n < N_RANDOM; n++) begin
            // let the pipe drain fully once
            if (n == 300) begin
                s_axis_tvalid <= 1'b0;
                while (alu_expected.size() != 0) @(posedge i_clk);
            end
            // receiver holds off while words keep coming
            if (n == 500) hold_req <= 1'b1;
            if (n == 540) hold_req <= 1'b0;
            send_word(($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                                  : 5'($urandom_range(0, 18)),
                      pick_operand(), pick_operand(), 5'($urandom), 0, '0,
                      iamd_pkg::ST_OK);
        end
        s_axis_tvalid <= 1'b0;
        stim_done     <= 1'b1;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (100) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(1, 2))
                    @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value  = m_axis_tdata[31:0];
            got.dest   = m_axis_tdata[36:32];
            got.wen    = m_axis_tdata[37];
            got.status = m_axis_tdata[39:38];
            if (alu_expected.size() == 0) begin
                $error("result word with none expected: %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = alu_expected.pop_front();
                if (got.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, got.value);
                    n_errors++;
                end
                if (got.dest !== want.dest) begin
                    $error("dest_out: expected %0d, got %0d", want.dest, got.dest);
                    n_errors++;
                end
                if (got.wen !== want.wen) begin
                    $error("write_enable: expected %0d, got %0d", want.wen, got.wen);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        n_errors  = 0;
        cycle_cnt = 0;
        while (!(stim_done && alu_expected.size() == 0) && cycle_cnt < MAX_CYCLE) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        if (cycle_cnt >= MAX_CYCLE) begin
            $display("Simulation FAILED");
        end else begin
            repeat (LATENCY) @(posedge i_clk);
            if (n_errors == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule
